FILE: src/fevcls_pkg.sv
// Package with shared types, limits, codes and the divide-by-ten helper.
package fevcls_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_UNIT_FAHRENHEIT = 3'd0,
    REG_AGE_GROUP       = 3'd1,
    REG_BEEP_ENABLE     = 3'd2,
    REG_VIBRATE_ENABLE  = 3'd3,
    REG_RECALL_MODE     = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    AGE_0_3_MONTHS  = 2'd0,
    AGE_3_36_MONTHS = 2'd1,
    AGE_OVER_36     = 2'd2,
    AGE_UNKNOWN     = 2'd3
  } age_t;

  typedef enum logic [1:0] {
    LED_NONE   = 2'd0,
    LED_GREEN  = 2'd1,
    LED_YELLOW = 2'd2,
    LED_RED    = 2'd3
  } led_t;

  typedef enum logic [1:0] {
    FACE_NONE  = 2'd0,
    FACE_SMILE = 2'd1,
    FACE_BAD   = 2'd2
  } face_t;

  typedef enum logic [1:0] {
    ALARM_NONE       = 2'd0,
    ALARM_LONG       = 2'd1,
    ALARM_FOUR_SHORT = 2'd2,
    ALARM_LONG_THREE = 2'd3
  } alarm_t;

  localparam logic signed [14:0] TEMP_MIN = -15'sd5000;
  localparam logic signed [14:0] TEMP_MAX = 15'sd15000;
  localparam logic signed [15:0] F_OFFSET = 16'sd3200;

  localparam logic signed [15:0] LIM_LO_C = 16'sd3400;
  localparam logic signed [15:0] LIM_HI_C = 16'sd4300;
  localparam logic signed [15:0] LIM_LO_F = 16'sd9320;
  localparam logic signed [15:0] LIM_HI_F = 16'sd10940;

  // Reciprocal of ten scaled by 2^19; exact floor for inputs below 2^15.
  localparam logic [31:0] RECIP_10 = 32'd52429;

  typedef struct packed {
    logic fahrenheit;
    age_t age_group;
    logic beep_enable;
    logic vibrate_enable;
    logic recall_mode;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] shown_temperature;
    led_t               led_color;
    face_t              face_icon;
    logic               lo_flag;
    logic               hi_flag;
    logic               fever_flag;
    alarm_t             alarm_pattern;
    logic               beep_on;
    logic               vibrate_on;
  } result_t;

  function automatic logic [11:0] div10(input logic [14:0] x);
    logic [31:0] p;
    p = {17'd0, x} * RECIP_10;
    return p[30:19];
  endfunction

  function automatic logic signed [15:0] normal_limit(input logic fahr, input age_t age);
    logic signed [15:0] lim;
    case (age)
      AGE_0_3_MONTHS:  lim = fahr ? 16'sd9940 : 16'sd3740;
      AGE_3_36_MONTHS: lim = fahr ? 16'sd9960 : 16'sd3760;
      default:         lim = fahr ? 16'sd9990 : 16'sd3770;
    endcase
    return lim;
  endfunction

  function automatic logic signed [15:0] fever_limit(input logic fahr, input age_t age);
    logic signed [15:0] lim;
    case (age)
      AGE_0_3_MONTHS:  lim = fahr ? LIM_HI_F : LIM_HI_C;
      AGE_3_36_MONTHS: lim = fahr ? 16'sd10130 : 16'sd3850;
      default:         lim = fahr ? 16'sd10300 : 16'sd3940;
    endcase
    return lim;
  endfunction

endpackage

FILE: src/fevcls_ifs.sv
// Valid/ready channel interfaces for temperature words, result words and register writes.
interface fevcls_temp_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] temperature_c;
  modport source (output valid, output temperature_c, input ready);
  modport sink   (input valid, input temperature_c, output ready);
endinterface

interface fevcls_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] shown_temperature;
  logic [1:0]         led_color;
  logic [1:0]         face_icon;
  logic               lo_flag;
  logic               hi_flag;
  logic               fever_flag;
  logic [1:0]         alarm_pattern;
  logic               beep_on;
  logic               vibrate_on;
  modport source (output valid, output shown_temperature, output led_color, output face_icon,
                  output lo_flag, output hi_flag, output fever_flag, output alarm_pattern,
                  output beep_on, output vibrate_on, input ready);
  modport sink   (input valid, input shown_temperature, input led_color, input face_icon,
                  input lo_flag, input hi_flag, input fever_flag, input alarm_pattern,
                  input beep_on, input vibrate_on, output ready);
endinterface

interface fevcls_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/fevcls_convert.sv
// Clamp of the Celsius reading and optional integer conversion to Fahrenheit.
module fevcls_convert
  import fevcls_pkg::*;
(
  input  logic signed [14:0] temperature_c,
  input  logic               fahrenheit,
  output logic signed [15:0] converted
);

  logic signed [14:0] clamped;
  logic [12:0]        mag;
  logic [13:0]        a_neg;
  logic [13:0]        d_neg;
  logic [14:0]        a_pos;
  logic [14:0]        d_pos;
  logic [11:0]        q_neg;
  logic [11:0]        q_pos;

  always_comb begin
    if (temperature_c < TEMP_MIN) begin
      clamped = TEMP_MIN;
    end else if (temperature_c > TEMP_MAX) begin
      clamped = TEMP_MAX;
    end else begin
      clamped = temperature_c;
    end
  end

  // Negative readings round the tenth downward in magnitude, the others round up.
  assign mag   = 13'(-clamped);
  assign a_neg = {mag, 1'b0};
  assign q_neg = div10({1'b0, a_neg});
  assign d_neg = a_neg - {2'b00, q_neg};

  assign a_pos = {clamped[13:0], 1'b0};
  assign q_pos = div10(a_pos + 15'd9);
  assign d_pos = a_pos - {3'b000, q_pos};

  always_comb begin
    if (!fahrenheit) begin
      converted = {clamped[14], clamped};
    end else if (clamped[14]) begin
      converted = F_OFFSET - $signed({2'b00, d_neg});
    end else begin
      converted = $signed({1'b0, d_pos}) + F_OFFSET;
    end
  end

endmodule

FILE: src/fevcls_classify.sv
// Rounding to a multiple of ten and classification into LED, face, flags and alarm.
module fevcls_classify
  import fevcls_pkg::*;
(
  input  logic signed [15:0] converted,
  input  cfg_t               cfg,
  output result_t            res
);

  logic [14:0]        mag;
  logic [14:0]        rnd_mag;
  logic [11:0]        q;
  logic signed [15:0] rounded;
  logic signed [15:0] lim_lo;
  logic signed [15:0] lim_hi;
  logic signed [15:0] lim_normal;
  logic signed [15:0] lim_fever;
  led_t               led;
  face_t              face;
  logic               lof;
  logic               hif;
  logic               fev;
  alarm_t             pat;

  assign mag     = converted[15] ? 15'(-converted) : converted[14:0];
  assign q       = div10(mag + 15'd5);
  assign rnd_mag = 15'({q, 3'b000}) + 15'({q, 1'b0});
  assign rounded = converted[15] ? -$signed({1'b0, rnd_mag}) : $signed({1'b0, rnd_mag});

  assign lim_lo     = cfg.fahrenheit ? LIM_LO_F : LIM_LO_C;
  assign lim_hi     = cfg.fahrenheit ? LIM_HI_F : LIM_HI_C;
  assign lim_normal = normal_limit(cfg.fahrenheit, cfg.age_group);
  assign lim_fever  = fever_limit(cfg.fahrenheit, cfg.age_group);

  always_comb begin
    led  = LED_NONE;
    face = FACE_NONE;
    lof  = 1'b0;
    hif  = 1'b0;
    fev  = 1'b0;
    pat  = ALARM_NONE;
    if (rounded < lim_lo) begin
      led  = LED_GREEN;
      face = FACE_SMILE;
      lof  = 1'b1;
      pat  = ALARM_FOUR_SHORT;
    end else if (rounded > lim_hi) begin
      led  = LED_RED;
      face = FACE_BAD;
      hif  = 1'b1;
      pat  = ALARM_LONG_THREE;
    end else if (cfg.age_group != AGE_UNKNOWN) begin
      if (rounded <= lim_normal) begin
        led  = LED_GREEN;
        face = FACE_SMILE;
        pat  = ALARM_LONG;
      end else if (cfg.age_group != AGE_0_3_MONTHS && rounded <= lim_fever) begin
        led  = LED_YELLOW;
        face = FACE_SMILE;
        pat  = ALARM_LONG;
      end else begin
        led  = LED_RED;
        face = FACE_BAD;
        fev  = 1'b1;
        pat  = ALARM_LONG_THREE;
      end
    end
  end

  always_comb begin
    res.shown_temperature = rounded;
    res.led_color         = led;
    res.face_icon         = face;
    res.lo_flag           = lof;
    res.hi_flag           = hif;
    res.fever_flag        = fev;
    res.alarm_pattern     = pat;
    res.beep_on           = (pat != ALARM_NONE) && cfg.beep_enable && !cfg.recall_mode;
    res.vibrate_on        = (pat != ALARM_NONE) && cfg.vibrate_enable && !cfg.recall_mode;
  end

endmodule

FILE: src/fever_temperature_classifier.sv
// Throughput: one word per cycle while the result sink is ready, through three register
// stages (input, converted, result), each of which loads whenever the stage after it is
// empty or being drained.
// Reset: synchronous, active high; clears all stage valid bits and loads the register
// defaults (Celsius, over 36 months, beep on, vibrate off, recall off).
module fever_temperature_classifier
  import fevcls_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  fevcls_temp_if.sink     temp,
  fevcls_result_if.source result,
  fevcls_cfg_if.sink      cfg
);

  cfg_t               regs;
  logic               s1_valid;
  logic signed [14:0] s1_temp;
  logic               s2_valid;
  logic signed [15:0] s2_value;
  logic signed [15:0] conv_value;
  result_t            res_next;
  logic               out_open;
  logic               s2_open;
  logic               s1_open;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.fahrenheit     <= 1'b0;
      regs.age_group      <= AGE_OVER_36;
      regs.beep_enable    <= 1'b1;
      regs.vibrate_enable <= 1'b0;
      regs.recall_mode    <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_UNIT_FAHRENHEIT: regs.fahrenheit     <= cfg.data[0];
        REG_AGE_GROUP:       regs.age_group      <= age_t'(cfg.data);
        REG_BEEP_ENABLE:     regs.beep_enable    <= cfg.data[0];
        REG_VIBRATE_ENABLE:  regs.vibrate_enable <= cfg.data[0];
        REG_RECALL_MODE:     regs.recall_mode    <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign out_open   = !result.valid || result.ready;
  assign s2_open    = !s2_valid || out_open;
  assign s1_open    = !s1_valid || s2_open;
  assign temp.ready = s1_open;

  fevcls_convert u_convert (
    .temperature_c (s1_temp),
    .fahrenheit    (regs.fahrenheit),
    .converted     (conv_value)
  );

  fevcls_classify u_classify (
    .converted (s2_value),
    .cfg       (regs),
    .res       (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (s1_open) begin
        s1_valid <= temp.valid;
      end
      if (s2_open) begin
        s2_valid <= s1_valid;
      end
      if (out_open) begin
        result.valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (temp.valid && s1_open) begin
      s1_temp <= temp.temperature_c;
    end
    if (s1_valid && s2_open) begin
      s2_value <= conv_value;
    end
    if (s2_valid && out_open) begin
      result.shown_temperature <= res_next.shown_temperature;
      result.led_color         <= res_next.led_color;
      result.face_icon         <= res_next.face_icon;
      result.lo_flag           <= res_next.lo_flag;
      result.hi_flag           <= res_next.hi_flag;
      result.fever_flag        <= res_next.fever_flag;
      result.alarm_pattern     <= res_next.alarm_pattern;
      result.beep_on           <= res_next.beep_on;
      result.vibrate_on        <= res_next.vibrate_on;
    end
  end

endmodule

FILE: src/fevcls_checker.sv
// Port-level checker for the classifier and its bind to the top level.
module fevcls_checker
  import fevcls_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] shown_temperature,
  input logic [1:0]  led_color,
  input logic [1:0]  face_icon,
  input logic        lo_flag,
  input logic        hi_flag,
  input logic        fever_flag,
  input logic [1:0]  alarm_pattern,
  input logic        beep_on,
  input logic        vibrate_on
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(shown_temperature) &&
      $stable(alarm_pattern))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_sound_needs_alarm: assert property (@(posedge clk) disable iff (rst)
    out_valid && (beep_on || vibrate_on) |-> alarm_pattern != ALARM_NONE)
    else $error("buzzer or motor on without an alarm pattern");

  a_lo_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && lo_flag |-> !hi_flag && !fever_flag && led_color == LED_GREEN &&
      alarm_pattern == ALARM_FOUR_SHORT)
    else $error("inconsistent low reading word");

  a_fever_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && (fever_flag || hi_flag) |-> led_color == LED_RED &&
      face_icon == FACE_BAD && alarm_pattern == ALARM_LONG_THREE)
    else $error("inconsistent fever reading word");

endmodule

bind fever_temperature_classifier fevcls_checker u_fevcls_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (result.valid),
  .out_ready         (result.ready),
  .shown_temperature (result.shown_temperature),
  .led_color         (result.led_color),
  .face_icon         (result.face_icon),
  .lo_flag           (result.lo_flag),
  .hi_flag           (result.hi_flag),
  .fever_flag        (result.fever_flag),
  .alarm_pattern     (result.alarm_pattern),
  .beep_on           (result.beep_on),
  .vibrate_on        (result.vibrate_on)
);

FILE: test/tb_fever_temperature_classifier.sv
// Self-checking testbench for the fever temperature classifier under random flow control.
module tb_fever_temperature_classifier;
  import fevcls_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASES       = 20;
  localparam int PHASE_LEN    = 50;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    cfg_t               settings;
    logic signed [14:0] reading;
    bit                 typed;
    result_t            outcome;
  } probe_t;

  logic clk = 1'b0;
  logic rst;

  always #5 clk = ~clk;

  fevcls_temp_if   temp_ch();
  fevcls_result_if res_ch();
  fevcls_cfg_if    cfg_ch();

  fever_temperature_classifier DUT (
    .clk    (clk),
    .rst    (rst),
    .temp   (temp_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  result_t due_readouts[$];
  probe_t  probes[$];
  cfg_t    shadow_cfg;
  bit      src_idle_on;
  bit      snk_idle_on;
  int      mismatches = 0;
  int      cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic result_t classify_reading(input logic signed [14:0] raw, input cfg_t c);
    int t;
    int a;
    int lo;
    int hi;
    int nrm;
    int yel;
    result_t r;
    t = int'(raw);
    if (t < -5000) t = -5000;
    if (t > 15000) t = 15000;
    if (c.fahrenheit) begin
      if (t < 0) begin
        a = -t * 2;
        a = a - a / 10;
        t = 3200 - a;
      end else begin
        a = t * 2;
        a = a - (a + 9) / 10;
        t = a + 3200;
      end
    end
    if (t < 0) t = -(((-t) + 5) / 10 * 10);
    else t = (t + 5) / 10 * 10;
    lo = c.fahrenheit ? int'(LIM_LO_F) : int'(LIM_LO_C);
    hi = c.fahrenheit ? int'(LIM_HI_F) : int'(LIM_HI_C);
    case (c.age_group)
      AGE_0_3_MONTHS: begin
        nrm = c.fahrenheit ? 9940 : 3740;
        yel = nrm;
      end
      AGE_3_36_MONTHS: begin
        nrm = c.fahrenheit ? 9960 : 3760;
        yel = c.fahrenheit ? 10130 : 3850;
      end
      default: begin
        nrm = c.fahrenheit ? 9990 : 3770;
        yel = c.fahrenheit ? 10300 : 3940;
      end
    endcase
    r = '0;
    r.shown_temperature = t[15:0];
    if (t < lo) begin
      r.led_color     = LED_GREEN;
      r.face_icon     = FACE_SMILE;
      r.lo_flag       = 1'b1;
      r.alarm_pattern = ALARM_FOUR_SHORT;
    end else if (t > hi) begin
      r.led_color     = LED_RED;
      r.face_icon     = FACE_BAD;
      r.hi_flag       = 1'b1;
      r.alarm_pattern = ALARM_LONG_THREE;
    end else if (c.age_group != AGE_UNKNOWN) begin
      if (t <= nrm) begin
        r.led_color     = LED_GREEN;
        r.face_icon     = FACE_SMILE;
        r.alarm_pattern = ALARM_LONG;
      end else if (t <= yel) begin
        r.led_color     = LED_YELLOW;
        r.face_icon     = FACE_SMILE;
        r.alarm_pattern = ALARM_LONG;
      end else begin
        r.led_color     = LED_RED;
        r.face_icon     = FACE_BAD;
        r.fever_flag    = 1'b1;
        r.alarm_pattern = ALARM_LONG_THREE;
      end
    end
    r.beep_on    = (r.alarm_pattern != ALARM_NONE) && c.beep_enable && !c.recall_mode;
    r.vibrate_on = (r.alarm_pattern != ALARM_NONE) && c.vibrate_enable && !c.recall_mode;
    return r;
  endfunction

  function automatic logic signed [14:0] random_reading();
    logic [31:0] draw;
    int          r;
    draw = $urandom;
    case ($urandom_range(0, 9))
      0: r = int'(draw[14:0]);
      1: r = draw[0] ? int'($urandom_range(14990, 15010)) : -int'($urandom_range(4990, 5010));
      2, 3: r = int'($urandom_range(0, 20000)) - 5000;
      default: r = int'($urandom_range(3300, 4400));
    endcase
    return r[14:0];
  endfunction

  task automatic compare_field(input string name, input logic signed [16:0] want,
                               input logic signed [16:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_readout();
    result_t want;
    if (due_readouts.size() == 0) begin
      $error("result word with none expected: shown_temperature %0d",
             res_ch.shown_temperature);
      mismatches++;
    end else begin
      want = due_readouts.pop_front();
      compare_field("shown_temperature", want.shown_temperature, res_ch.shown_temperature);
      compare_field("led_color", want.led_color, res_ch.led_color);
      compare_field("face_icon", want.face_icon, res_ch.face_icon);
      compare_field("lo_flag", want.lo_flag, res_ch.lo_flag);
      compare_field("hi_flag", want.hi_flag, res_ch.hi_flag);
      compare_field("fever_flag", want.fever_flag, res_ch.fever_flag);
      compare_field("alarm_pattern", want.alarm_pattern, res_ch.alarm_pattern);
      compare_field("beep_on", want.beep_on, res_ch.beep_on);
      compare_field("vibrate_on", want.vibrate_on, res_ch.vibrate_on);
    end
  endtask

  task automatic drive_reading(input logic signed [14:0] reading, input bit typed,
                               input result_t outcome);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      temp_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    temp_ch.valid         <= 1'b1;
    temp_ch.temperature_c <= reading;
    @(posedge clk);
    while (temp_ch.ready !== 1'b1) @(posedge clk);
    due_readouts.push_back(typed ? outcome : classify_reading(reading, shadow_cfg));
  endtask

  task automatic drain();
    temp_ch.valid <= 1'b0;
    while (due_readouts.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    case (idx)
      REG_UNIT_FAHRENHEIT: shadow_cfg.fahrenheit     = value[0];
      REG_AGE_GROUP:       shadow_cfg.age_group      = age_t'(value);
      REG_BEEP_ENABLE:     shadow_cfg.beep_enable    = value[0];
      REG_VIBRATE_ENABLE:  shadow_cfg.vibrate_enable = value[0];
      REG_RECALL_MODE:     shadow_cfg.recall_mode    = value[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input cfg_t want);
    logic [CFG_DATA_W-1:0]  noise;
    logic [CFG_INDEX_W-1:0] spare;
    noise = CFG_DATA_W'($urandom);
    spare = CFG_INDEX_W'($urandom_range(int'(REG_RECALL_MODE) + 1, (1 << CFG_INDEX_W) - 1));
    drain();
    write_reg(REG_UNIT_FAHRENHEIT, {noise[1], want.fahrenheit});
    write_reg(REG_AGE_GROUP, want.age_group);
    write_reg(REG_BEEP_ENABLE, {noise[0], want.beep_enable});
    write_reg(REG_VIBRATE_ENABLE, {noise[1], want.vibrate_enable});
    write_reg(REG_RECALL_MODE, {noise[0], want.recall_mode});
    if ($urandom_range(0, 1)) write_reg(spare, noise);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic add_probe(input cfg_t settings, input logic signed [14:0] reading,
                           input bit typed, input result_t outcome);
    probe_t p;
    p.settings = settings;
    p.reading  = reading;
    p.typed    = typed;
    p.outcome  = outcome;
    probes.push_back(p);
  endtask

  initial begin
    int      stall;
    res_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = snk_idle_on ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (res_ch.valid !== 1'b1) @(posedge clk);
      check_readout();
    end
  end

  initial begin
    cfg_t rdef;
    cfg_t fdeg;
    cfg_t unk;
    cfg_t young;
    cfg_t toddler;
    cfg_t rc;
    rst                   <= 1'b1;
    temp_ch.valid         <= 1'b0;
    temp_ch.temperature_c <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= '0;
    cfg_ch.data           <= '0;
    rdef       = cfg_t'{1'b0, AGE_OVER_36, 1'b1, 1'b0, 1'b0};
    fdeg       = cfg_t'{1'b1, AGE_OVER_36, 1'b1, 1'b1, 1'b0};
    unk        = cfg_t'{1'b0, AGE_UNKNOWN, 1'b1, 1'b1, 1'b0};
    young      = cfg_t'{1'b0, AGE_0_3_MONTHS, 1'b1, 1'b0, 1'b0};
    toddler    = cfg_t'{1'b1, AGE_3_36_MONTHS, 1'b0, 1'b1, 1'b1};
    shadow_cfg = rdef;
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;

    add_probe(rdef, 15'sd3700, 1'b1, result_t'{16'sd3700, LED_GREEN, FACE_SMILE,
              1'b0, 1'b0, 1'b0, ALARM_LONG, 1'b1, 1'b0});
    add_probe(rdef, -15'sd16384, 1'b1, result_t'{-16'sd5000, LED_GREEN, FACE_SMILE,
              1'b1, 1'b0, 1'b0, ALARM_FOUR_SHORT, 1'b1, 1'b0});
    add_probe(rdef, 15'sd16383, 1'b1, result_t'{16'sd15000, LED_RED, FACE_BAD,
              1'b0, 1'b1, 1'b0, ALARM_LONG_THREE, 1'b1, 1'b0});
    add_probe(rdef, -15'sd5001, 1'b0, '0);
    add_probe(rdef, 15'sd15001, 1'b0, '0);
    add_probe(rdef, 15'sd3394, 1'b0, '0);
    add_probe(rdef, 15'sd3395, 1'b0, '0);
    add_probe(rdef, 15'sd3400, 1'b1, result_t'{16'sd3400, LED_GREEN, FACE_SMILE,
              1'b0, 1'b0, 1'b0, ALARM_LONG, 1'b1, 1'b0});
    add_probe(rdef, 15'sd3775, 1'b1, result_t'{16'sd3780, LED_YELLOW, FACE_SMILE,
              1'b0, 1'b0, 1'b0, ALARM_LONG, 1'b1, 1'b0});
    add_probe(rdef, 15'sd3940, 1'b0, '0);
    add_probe(rdef, 15'sd3945, 1'b1, result_t'{16'sd3950, LED_RED, FACE_BAD,
              1'b0, 1'b0, 1'b1, ALARM_LONG_THREE, 1'b1, 1'b0});
    add_probe(rdef, 15'sd4304, 1'b0, '0);
    add_probe(rdef, 15'sd4305, 1'b1, result_t'{16'sd4310, LED_RED, FACE_BAD,
              1'b0, 1'b1, 1'b0, ALARM_LONG_THREE, 1'b1, 1'b0});
    add_probe(rdef, -15'sd5, 1'b0, '0);
    add_probe(rdef, -15'sd4, 1'b0, '0);
    add_probe(rdef, 15'sd0, 1'b0, '0);
    add_probe(fdeg, -15'sd5000, 1'b1, result_t'{-16'sd5800, LED_GREEN, FACE_SMILE,
              1'b1, 1'b0, 1'b0, ALARM_FOUR_SHORT, 1'b1, 1'b1});
    add_probe(fdeg, 15'sd15000, 1'b1, result_t'{16'sd30200, LED_RED, FACE_BAD,
              1'b0, 1'b1, 1'b0, ALARM_LONG_THREE, 1'b1, 1'b1});
    add_probe(fdeg, -15'sd1, 1'b0, '0);
    add_probe(fdeg, 15'sd3700, 1'b0, '0);
    add_probe(fdeg, 15'sd3735, 1'b0, '0);
    add_probe(unk, 15'sd3700, 1'b1, result_t'{16'sd3700, LED_NONE, FACE_NONE,
              1'b0, 1'b0, 1'b0, ALARM_NONE, 1'b0, 1'b0});
    add_probe(unk, 15'sd3300, 1'b0, '0);
    add_probe(young, 15'sd3750, 1'b0, '0);
    add_probe(toddler, 15'sd3800, 1'b0, '0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (probes[i]) begin
      if (probes[i].settings != shadow_cfg) set_config(probes[i].settings);
      drive_reading(probes[i].reading, probes[i].typed, probes[i].outcome);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        rc = '0;
      end else if (ph == 1) begin
        rc = '1;
      end else begin
        rc.fahrenheit     = 1'($urandom_range(0, 1));
        rc.age_group      = age_t'($urandom_range(0, 3));
        rc.beep_enable    = 1'($urandom_range(0, 1));
        rc.vibrate_enable = 1'($urandom_range(0, 1));
        rc.recall_mode    = $urandom_range(0, 3) == 0;
      end
      set_config(rc);
      src_idle_on = $urandom_range(0, 3) != 0;
      snk_idle_on = $urandom_range(0, 3) != 0;
      for (int k = 0; k < PHASE_LEN; k++) drive_reading(random_reading(), 1'b0, '0);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
